@@ design/pwmc_pkg.sv @@
// pwmc_pkg: shared widths, register indexes and limit codes for the PID block.
// No dependencies; used by the top level and its port checker.
`default_nettype none

package pwmc_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam int DATA_W  = 32;
	localparam int INTEG_W = 48;
	localparam int MAG_W   = 31;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_MAG = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_MAG = 3'd4;

	// limit_hit codes
	localparam logic [1:0] LIMIT_NONE   = 2'd0;
	localparam logic [1:0] LIMIT_RAISED = 2'd1;
	localparam logic [1:0] LIMIT_CUT    = 2'd2;

	localparam logic signed [DATA_W-1:0] DRIVE_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] DRIVE_MIN = 32'sh8000_0000;

endpackage

`default_nettype wire

@@ design/pid_with_magnitude_clamp_top.sv @@
// pid_with_magnitude_clamp_top: pipelined fixed-point PID with output magnitude limits.
// Depends on pwmc_pkg for widths, register indexes and limit codes.
//
// channel | direction | handshake              | payload
// --------+-----------+------------------------+--------------------------
// input   | in        | in_valid / in_stall    | error_in[31:0], restart
// output  | out       | out_valid / out_stall  | drive[31:0], limit_hit[1:0]
// config  | in        | cfg_we (no handshake)  | cfg_index[2:0], cfg_data
//
// One word enters per cycle while in_stall is low; its result then passes the
// state update, multiply, shift/bound, sum/saturate and limit stages in order.
// The integral and previous-error registers are updated as each word is taken.
// Reset clears the integral, the previous error and all stage valids, and
// loads the gain and limit registers with their defaults.
// out_stall backs up the stage chain; in_stall rises only when all five
// stages hold words and the output is stalled.
`default_nettype none

module pid_with_magnitude_clamp_top #(
	parameter int FRAC_BITS = pwmc_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// configuration write port
	input  wire logic                                  cfg_we,
	input  wire logic [pwmc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [pwmc_pkg::DATA_W-1:0]           cfg_data,
	// input channel
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [pwmc_pkg::DATA_W-1:0]    error_in,
	input  wire logic                                  restart,
	// output channel
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [pwmc_pkg::DATA_W-1:0]         drive,
	output logic [1:0]                                 limit_hit
);

	localparam int DW = pwmc_pkg::DATA_W;
	localparam int IW = pwmc_pkg::INTEG_W;
	localparam int MW = pwmc_pkg::MAG_W;

	// register defaults: 100.0, 0.01 and 0.08 in the chosen format
	localparam logic signed [DW-1:0] GAIN_P_RST = DW'(100 << FRAC_BITS);
	localparam logic [MW-1:0] MIN_RST = MW'(((1 << FRAC_BITS) + 50) / 100);
	localparam logic [MW-1:0] MAX_RST = MW'(((8 << FRAC_BITS) + 50) / 100);

	// integral split: high part g*hi is weighted by 2^(24-FRAC_BITS)
	localparam int ISPLIT = 24;
	localparam int ISH    = ISPLIT - FRAC_BITS;
	localparam int P_W    = 2 * DW;          // gain_p * err
	localparam int D_W    = 2 * DW + 1;      // gain_d * deriv
	localparam int A_W    = DW + IW - ISPLIT; // gain_i * hi
	localparam int B_W    = DW + ISPLIT + 1; // gain_i * lo (lo unsigned)
	localparam int T_W    = 58;              // bounded integral high term
	localparam int IT_W   = T_W + 1;
	localparam int PD_W   = D_W + 1;
	localparam int S_W    = PD_W + 1;

	localparam logic signed [T_W-1:0] ILIM   = T_W'(1) <<< (DW + FRAC_BITS);
	localparam logic signed [T_W-1:0] IBOUND = T_W'(1) <<< 56;

	// ---------------- configuration registers ----------------
	logic signed [DW-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic [MW-1:0]        min_mag_q, max_mag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q  <= GAIN_P_RST;
			gain_i_q  <= '0;
			gain_d_q  <= '0;
			min_mag_q <= MIN_RST;
			max_mag_q <= MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pwmc_pkg::CFG_GAIN_P:  gain_p_q  <= $signed(cfg_data);
				pwmc_pkg::CFG_GAIN_I:  gain_i_q  <= $signed(cfg_data);
				pwmc_pkg::CFG_GAIN_D:  gain_d_q  <= $signed(cfg_data);
				pwmc_pkg::CFG_MIN_MAG: min_mag_q <= cfg_data[MW-1:0];
				pwmc_pkg::CFG_MAX_MAG: max_mag_q <= cfg_data[MW-1:0];
				default: ;  // unmapped index: ignored
			endcase
		end
	end

	// ---------------- stage flow control ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	logic take;

	assign rdy_s5   = !v_s5 || !out_stall;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;
	assign take     = in_valid && rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// ---------------- controller state (updated on accept) ----------------
	logic signed [DW-1:0] prev_err_q;
	logic signed [IW-1:0] integ_q;
	logic signed [DW-1:0] prev_eff;
	logic signed [IW-1:0] integ_eff, integ_new;
	logic signed [IW:0]   integ_sum;
	logic signed [DW:0]   deriv;

	always_comb begin
		prev_eff  = restart ? '0 : prev_err_q;
		integ_eff = restart ? '0 : integ_q;
		integ_sum = (IW+1)'(integ_eff) + (IW+1)'(prev_eff);
		// saturate to 48 bits when the carry disagrees with the sign
		if (integ_sum[IW] != integ_sum[IW-1])
			integ_new = integ_sum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
		else
			integ_new = integ_sum[IW-1:0];
		deriv = (DW+1)'(error_in) - (DW+1)'(prev_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			integ_q    <= '0;
		end else if (take) begin
			prev_err_q <= error_in;
			integ_q    <= integ_new;
		end
	end

	// stage 1: operands
	logic signed [DW-1:0] err_s1;
	logic signed [DW:0]   deriv_s1;
	logic signed [IW-1:0] integ_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			err_s1   <= error_in;
			deriv_s1 <= deriv;
			integ_s1 <= integ_new;
		end
	end

	// stage 2: four products, each at most 32 x 33 bits
	logic signed [IW-ISPLIT-1:0] int_hi;
	logic signed [ISPLIT:0]      int_lo;
	logic signed [P_W-1:0] mul_p;
	logic signed [D_W-1:0] mul_d;
	logic signed [A_W-1:0] mul_a;
	logic signed [B_W-1:0] mul_b;

	assign int_hi = integ_s1[IW-1:ISPLIT];
	assign int_lo = $signed({1'b0, integ_s1[ISPLIT-1:0]});
	assign mul_p  = gain_p_q * err_s1;
	assign mul_d  = gain_d_q * deriv_s1;
	assign mul_a  = gain_i_q * int_hi;
	assign mul_b  = gain_i_q * int_lo;

	logic signed [P_W-1:0] p_s2;
	logic signed [D_W-1:0] d_s2;
	logic signed [A_W-1:0] a_s2;
	logic signed [B_W-1:0] b_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			p_s2 <= mul_p;
			d_s2 <= mul_d;
			a_s2 <= mul_a;
			b_s2 <= mul_b;
		end
	end

	// stage 3: floor shifts, bounded integral term, partial sums
	logic signed [P_W-1:0]  tp;
	logic signed [D_W-1:0]  td;
	logic signed [T_W-1:0]  a_ext, ta;
	logic signed [B_W-1:0]  tb;
	logic signed [PD_W-1:0] pd_sum;
	logic signed [IT_W-1:0] it_sum;

	always_comb begin
		tp    = p_s2 >>> FRAC_BITS;
		td    = d_s2 >>> FRAC_BITS;
		tb    = b_s2 >>> FRAC_BITS;
		a_ext = T_W'(a_s2);
		// beyond the bound the term dwarfs the 32-bit range anyway
		if (a_ext > ILIM)
			ta = IBOUND;
		else if (a_ext < -ILIM)
			ta = -IBOUND;
		else
			ta = a_ext <<< ISH;
		pd_sum = PD_W'(tp) + PD_W'(td);
		it_sum = IT_W'(ta) + IT_W'(tb);
	end

	logic signed [PD_W-1:0] pd_s3;
	logic signed [IT_W-1:0] it_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			pd_s3 <= pd_sum;
			it_s3 <= it_sum;
		end
	end

	// stage 4: full sum, saturate to 32 bits
	logic signed [S_W-1:0] full_sum;
	logic signed [DW-1:0]  sat_sum;

	always_comb begin
		full_sum = S_W'(pd_s3) + S_W'(it_s3);
		if (full_sum[S_W-1:DW-1] == {(S_W-DW+1){full_sum[DW-1]}})
			sat_sum = full_sum[DW-1:0];
		else if (full_sum[S_W-1])
			sat_sum = pwmc_pkg::DRIVE_MIN;
		else
			sat_sum = pwmc_pkg::DRIVE_MAX;
	end

	logic signed [DW-1:0] sum_s4;

	always_ff @(posedge clk) begin
		if (rdy_s4) sum_s4 <= sat_sum;
	end

	// stage 5: magnitude limits, sign kept; zero counts as positive
	logic          neg;
	logic [DW-1:0] mag_raw, mag_lim;
	logic [1:0]    hit;
	logic signed [DW-1:0] limited;

	always_comb begin
		neg     = sum_s4[DW-1];
		mag_raw = neg ? (DW'(0) - DW'(sum_s4)) : DW'(sum_s4);
		mag_lim = mag_raw;
		hit     = pwmc_pkg::LIMIT_NONE;
		if (mag_raw < {1'b0, min_mag_q}) begin
			mag_lim = {1'b0, min_mag_q};
			hit     = pwmc_pkg::LIMIT_RAISED;
		end
		// max applied last so it wins over an inverted min
		if (mag_lim > {1'b0, max_mag_q}) begin
			mag_lim = {1'b0, max_mag_q};
			hit     = pwmc_pkg::LIMIT_CUT;
		end
		limited = neg ? $signed(DW'(0) - mag_lim) : $signed(mag_lim);
	end

	logic signed [DW-1:0] drive_s5;
	logic [1:0]           hit_s5;

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			drive_s5 <= limited;
			hit_s5   <= hit;
		end
	end

	assign out_valid = v_s5;
	assign drive     = drive_s5;
	assign limit_hit = hit_s5;

endmodule

`default_nettype wire

@@ design/pwmc_checker.sv @@
// pwmc_port_props: port-level checks for the PID block, attached by bind.
// Depends on pwmc_pkg for limit codes and the drive range.
`default_nettype none

module pwmc_port_props (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic signed [31:0] drive,
	input wire logic [1:0]         limit_hit
);

	// only the three defined limit codes are ever shown
	a_hit_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (limit_hit == pwmc_pkg::LIMIT_NONE ||
			limit_hit == pwmc_pkg::LIMIT_RAISED || limit_hit == pwmc_pkg::LIMIT_CUT))
		else $error("limit_hit carries an undefined code");

	// the max limit is 31 bits, so the most negative word can never appear
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drive != pwmc_pkg::DRIVE_MIN)
		else $error("drive outside the limited magnitude range");

	// input only backs up when the output is full and stalled
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output could drain");

	// no word appears right after reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("output word present right after reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(drive) && $stable(limit_hit)))
		else $error("stalled output word changed");

endmodule

bind pid_with_magnitude_clamp_top pwmc_port_props u_pwmc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.drive     (drive),
	.limit_hit (limit_hit)
);

`default_nettype wire

@@ dv/pwmc_checker.sv @@
// pwmc_checker: watches the PID block's config port and both word channels, predicts each
// result from its own copy of the gains, limits and controller state, and compares.
// Depends on pwmc_pkg only.
`timescale 1ns / 100ps

module pwmc_checker #(
	parameter int FRAC_BITS = pwmc_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pwmc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pwmc_pkg::DATA_W-1:0]         cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic signed [pwmc_pkg::DATA_W-1:0]  error_in,
	input  logic                                restart,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic signed [pwmc_pkg::DATA_W-1:0]  drive,
	input  logic [1:0]                          limit_hit,
	output int                                  fail_count,
	output int                                  outstanding
);
	import pwmc_pkg::*;

	typedef logic signed [95:0] acc_t;
	typedef struct packed {
		logic signed [DATA_W-1:0] level;
		logic [1:0]               hit;
	} drive_word_t;

	localparam acc_t INTEG_HI = {{49{1'b0}}, {47{1'b1}}};
	localparam acc_t INTEG_LO = {{49{1'b1}}, {47{1'b0}}};
	localparam acc_t SUM_HI   = DRIVE_MAX;
	localparam acc_t SUM_LO   = DRIVE_MIN;

	logic signed [DATA_W-1:0] kp, ki, kd;
	logic [MAG_W-1:0]         mag_floor, mag_ceil;
	logic signed [DATA_W-1:0] last_err;
	acc_t                     err_sum;
	drive_word_t              drive_q[$];
	drive_word_t              want;

	// one controller step; updates the running integral and the previous error
	function automatic drive_word_t pid_step(input logic signed [DATA_W-1:0] err,
	                                         input logic clr);
		acc_t e, prev, rate, gp, gi, gd, sum, mag, lo_w, hi_w;
		logic neg;
		drive_word_t res;
		if (clr) begin
			last_err = '0;
			err_sum  = '0;
		end
		prev    = last_err;
		err_sum = err_sum + prev;
		if (err_sum > INTEG_HI)
			err_sum = INTEG_HI;
		if (err_sum < INTEG_LO)
			err_sum = INTEG_LO;
		e        = err;
		rate     = e - prev;
		last_err = err;
		gp = kp;
		gi = ki;
		gd = kd;
		// products are exact at this width; >>> floors
		sum = ((gp * e) >>> FRAC_BITS) + ((gd * rate) >>> FRAC_BITS)
			+ ((gi * err_sum) >>> FRAC_BITS);
		if (sum > SUM_HI)
			sum = SUM_HI;
		if (sum < SUM_LO)
			sum = SUM_LO;
		neg     = sum < 0;
		mag     = neg ? -sum : sum;
		lo_w    = mag_floor;
		hi_w    = mag_ceil;
		res.hit = LIMIT_NONE;
		if (mag < lo_w) begin
			mag     = lo_w;
			res.hit = LIMIT_RAISED;
		end
		if (mag > hi_w) begin
			mag     = hi_w;
			res.hit = LIMIT_CUT;
		end
		sum       = neg ? -mag : mag;
		res.level = sum[DATA_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp          = 100 << FRAC_BITS;
			ki          = '0;
			kd          = '0;
			mag_floor   = ((1 << FRAC_BITS) + 50) / 100;
			mag_ceil    = ((8 << FRAC_BITS) + 50) / 100;
			last_err    = '0;
			err_sum     = '0;
			fail_count  = 0;
			drive_q.delete();
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_GAIN_P:  kp = cfg_data;
					CFG_GAIN_I:  ki = cfg_data;
					CFG_GAIN_D:  kd = cfg_data;
					CFG_MIN_MAG: mag_floor = cfg_data[MAG_W-1:0];
					CFG_MAX_MAG: mag_ceil = cfg_data[MAG_W-1:0];
					default: ;  // unused indexes are dropped
				endcase
			end
			if (in_valid && !in_stall)
				drive_q.push_back(pid_step(error_in, restart));
			if (out_valid && !out_stall) begin
				if (drive_q.size() == 0) begin
					$display("%0t: unexpected word: drive %0d limit_hit %0d",
						$time, drive, limit_hit);
					fail_count++;
				end else begin
					want = drive_q.pop_front();
					if (drive !== want.level) begin
						$display("%0t: drive mismatch: expected %0d, got %0d",
							$time, want.level, drive);
						fail_count++;
					end
					if (limit_hit !== want.hit) begin
						$display("%0t: limit_hit mismatch: expected %0d, got %0d",
							$time, want.hit, limit_hit);
						fail_count++;
					end
				end
			end
			outstanding = drive_q.size();
		end
	end

endmodule

@@ dv/tb_pid_with_magnitude_clamp_top.sv @@
// tb_pid_with_magnitude_clamp_top: clock, reset, config writes and word traffic for the
// PID block with output limits; the verdict comes from pwmc_checker's failure count.
// Depends on pwmc_pkg, pid_with_magnitude_clamp_top and pwmc_checker.
`timescale 1ns / 100ps

module tb_pid_with_magnitude_clamp_top;
	import pwmc_pkg::*;

	// longest natural quiet stretch is the long hold plus a gap and the 5-stage drain
	localparam int WATCHDOG_CYCLES = 1000;
	localparam int HOLD_CYCLES     = 60;
	// full-scale error steps per sign in the integral run
	localparam int SAT_STEPS       = 40;
	localparam int RAND_PHASES     = 8;
	localparam int WORDS_PER_PHASE = 170;
	localparam int PRESSURE_PHASE  = 1;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [DATA_W-1:0]        cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [DATA_W-1:0] error_in;
	logic                     restart;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [DATA_W-1:0] drive;
	logic [1:0]               limit_hit;
	int                       fail_count;
	int                       outstanding;

	bit idle_on;      // random gaps on the sender and stalls on the receiver
	bit hold_req;     // asks the receiver for one long stall
	int quiet_cycles;

	pid_with_magnitude_clamp_top DUT (.*);

	pwmc_checker #(.FRAC_BITS(FRAC_BITS_DEF)) u_checker (.*);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: any cycle without a word moving on either channel counts toward the limit.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("%0t: watchdog: no word moved for %0d cycles", $time, quiet_cycles);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Receiver: random stall bursts while idling is on; one long hold on request so the
	// five stages fill and in_stall has to rise while the sender keeps offering words.
	initial begin
		bit held;
		held      = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
				held = 1'b1;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Offers one word and returns at the edge that takes it. Valid stays high into the
	// next word unless a gap is drawn, so it never drops and rises in one step.
	task automatic send_word(input logic signed [DATA_W-1:0] err, input logic clr);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_valid <= 1'b1;
		error_in <= err;
		restart  <= clr;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Every word yields a result, so an empty checker queue means the pipe is empty;
	// the extra cycles only keep config writes clear of the last result.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (outstanding == 0);
		repeat (8) @(negedge clk);
	endtask

	// mostly small gains so that results land between the limits, some extremes
	function automatic logic [DATA_W-1:0] pick_gain();
		case ($urandom_range(0, 6))
			0: return '0;
			1: return DRIVE_MAX;
			2: return DRIVE_MIN;
			6: return $urandom();
			default: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
		endcase
	endfunction

	// bit 31 of the data is dropped by the limit registers, full random covers it
	function automatic logic [DATA_W-1:0] pick_mag();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return DRIVE_MAX;
			2: return $urandom_range(0, 1 << 12);
			3: return $urandom_range(0, 1 << 24);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_error();
		case ($urandom_range(0, 7))
			0, 1: return int'($urandom_range(0, 1 << 13)) - (1 << 12);
			2, 3: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
			4: return DRIVE_MAX;
			5: return DRIVE_MIN;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		int sent;
		int run_len;
		logic signed [DATA_W-1:0] walk;

		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		error_in  = '0;
		restart   = 1'b0;
		idle_on   = 1'b1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset gains and limits: gain 100, limits 0.01 / 0.08. A zero sum is taken as
		// positive and raised to the minimum; small sums raised, large ones cut.
		send_word(0, 1'b1);
		send_word(20, 1'b0);
		send_word(-30, 1'b0);
		send_word(60, 1'b0);
		send_word(-1, 1'b0);
		send_word(DRIVE_MAX, 1'b0);
		send_word(DRIVE_MIN, 1'b0);
		send_word(5, 1'b1);
		drain();

		// writes past the last register must leave everything as it was
		for (int i = CFG_MAX_MAG + 1; i < (1 << CFG_IDX_W); i++)
			cfg_write(CFG_IDX_W'(i), '1);
		// minimum above maximum: the maximum wins, every result is cut to zero
		cfg_write(CFG_GAIN_P, '0);
		cfg_write(CFG_GAIN_I, DRIVE_MAX);
		cfg_write(CFG_GAIN_D, DRIVE_MIN);
		cfg_write(CFG_MIN_MAG, '1);
		cfg_write(CFG_MAX_MAG, '0);
		send_word(DRIVE_MAX, 1'b1);
		send_word(DRIVE_MIN, 1'b0);
		send_word(0, 1'b0);
		send_word(1, 1'b0);
		drain();

		// both limits zero with a zero sum: passes through as zero, no limit flagged
		cfg_write(CFG_GAIN_I, '0);
		cfg_write(CFG_GAIN_D, '0);
		cfg_write(CFG_MIN_MAG, '0);
		send_word(0, 1'b1);
		send_word(12345, 1'b0);
		drain();

		// extreme gains against extreme errors and full-swing derivatives
		cfg_write(CFG_GAIN_P, DRIVE_MIN);
		cfg_write(CFG_GAIN_I, DRIVE_MIN);
		cfg_write(CFG_GAIN_D, DRIVE_MAX);
		cfg_write(CFG_MAX_MAG, DRIVE_MAX);
		send_word(DRIVE_MAX, 1'b1);
		send_word(DRIVE_MIN, 1'b0);
		send_word(DRIVE_MAX, 1'b0);
		send_word(DRIVE_MIN, 1'b0);
		send_word(0, 1'b0);
		send_word(-1, 1'b0);
		drain();

		// Integral runs, both signs. Gain_p of -1.0 and gain_i of one LSB keep the sum
		// near full scale, so the growing integral shows up in the low bits.
		idle_on = 1'b0;
		cfg_write(CFG_GAIN_P, -(1 << FRAC_BITS_DEF));
		cfg_write(CFG_GAIN_I, 1);
		cfg_write(CFG_GAIN_D, '0);
		cfg_write(CFG_MIN_MAG, '0);
		cfg_write(CFG_MAX_MAG, DRIVE_MAX);
		send_word(DRIVE_MAX, 1'b1);
		for (int k = 0; k < SAT_STEPS; k++)
			send_word(DRIVE_MAX, 1'b0);
		send_word(DRIVE_MIN, 1'b1);
		for (int k = 0; k < SAT_STEPS; k++)
			send_word(DRIVE_MIN, 1'b0);

		// Random phases: new gains and limits each time, then runs of a slowly moving
		// error that each start with a restart, as a fresh move would, plus odd jumps.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain();
			cfg_write(CFG_GAIN_P, pick_gain());
			cfg_write(CFG_GAIN_I, pick_gain());
			cfg_write(CFG_GAIN_D, pick_gain());
			cfg_write(CFG_MIN_MAG, pick_mag());
			cfg_write(CFG_MAX_MAG, pick_mag());
			// the last phase runs flat out; the pressure phase keeps the sender busy
			idle_on = ph != RAND_PHASES - 1 && ph != PRESSURE_PHASE
				&& $urandom_range(0, 3) != 0;
			if (ph == PRESSURE_PHASE)
				hold_req = 1'b1;
			sent = 0;
			while (sent < WORDS_PER_PHASE) begin
				run_len = $urandom_range(4, 40);
				walk    = pick_error();
				for (int k = 0; k < run_len && sent < WORDS_PER_PHASE; k++) begin
					if ($urandom_range(0, 7) == 0)
						walk = pick_error();
					else
						walk = walk + (int'($urandom_range(0, 512)) - 256);
					send_word(walk, k == 0 || $urandom_range(0, 31) == 0);
					sent++;
				end
			end
		end

		drain();
		repeat (12) @(posedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
